// ===== design/unordered_list_table_engine_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared clocked property forms for the list engine checkers.
// ----------------------------------------------------------------------------
`ifndef UNORDERED_LIST_TABLE_ENGINE_CORE_ASSERT_SVH
`define UNORDERED_LIST_TABLE_ENGINE_CORE_ASSERT_SVH

// same-cycle implication
`define ULTE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ULTE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/ulte_pkg.sv =====
// ----------------------------------------------------------------------------
// ulte_pkg
// Types and constants of the unordered list engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ulte_pkg;

    localparam int ACTION_W = 3;
    localparam int POS_W    = 8;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 3;
    localparam int OCC_W    = 9;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH   = 3'd0,
        ACT_POP    = 3'd1,
        ACT_REMOVE = 3'd2,
        ACT_ERASE  = 3'd3,
        ACT_FIND   = 3'd4,
        ACT_READ   = 3'd5,
        ACT_WRITE  = 3'd6,
        ACT_CLEAR  = 3'd7
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 3'd0,
        STAT_FULL     = 3'd1,
        STAT_RANGE    = 3'd2,
        STAT_NOTFOUND = 3'd3,
        STAT_EMPTY    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MOVE,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== design/ulte_if.sv =====
// ----------------------------------------------------------------------------
// ulte_req_if / ulte_rsp_if
// Valid/ready channels carrying list requests and their results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ulte_req_if;
    logic                                 valid;
    logic                                 ready;
    logic        [ulte_pkg::ACTION_W-1:0] action;
    logic        [ulte_pkg::POS_W-1:0]    position;
    logic signed [ulte_pkg::WORD_W-1:0]   word;

    modport source (output valid, output action, output position, output word, input ready);
    modport sink   (input valid, input action, input position, input word, output ready);
endinterface

interface ulte_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [ulte_pkg::WORD_W-1:0]   read_word;
    logic        [ulte_pkg::POS_W-1:0]    found_position;
    logic        [ulte_pkg::STATUS_W-1:0] status;
    logic        [ulte_pkg::OCC_W-1:0]    occupancy;

    modport source (output valid, output read_word, output found_position,
                    output status, output occupancy, input ready);
    modport sink   (input valid, input read_word, input found_position,
                    input status, input occupancy, output ready);
endinterface

`default_nettype wire

// ===== design/unordered_list_table_engine_core.sv =====
// ----------------------------------------------------------------------------
// unordered_list_table_engine_core
// Fixed-capacity list of signed words held in one synchronous RAM, with
// swap-with-last removal and linear search.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                       | accepted when
//  i_req   | in  | action, position, word                        | valid & ready
//  o_rsp   | out | read_word, found_position, status, occupancy  | valid & ready
//
//  Find and erase scan the RAM one entry a cycle through its single read
//  port. An in-range remove and an erase hit pass the move state, where the
//  last entry fills the freed slot; every request ends in the done state.
//  Reset clears the count, state and result valid only; entries are not cleared.
//  A result waits in the output register while the next request is taken;
//  a finished request holds until that register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module unordered_list_table_engine_core #(
    parameter int CAPACITY = 256
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ulte_req_if.sink   i_req,
    ulte_rsp_if.source o_rsp
);
    import ulte_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic signed [WORD_W-1:0] mem [CAPACITY];

    t_state                   r_state, n_state;
    logic        [CW-1:0]     r_count, n_count;
    logic        [CW-1:0]     r_scan, n_scan;
    logic                     r_cmp_valid, n_cmp_valid;
    logic        [AW-1:0]     r_cmp_idx, n_cmp_idx;
    logic signed [WORD_W-1:0] r_key, n_key;
    logic        [AW-1:0]     r_tgt, n_tgt;
    logic                     r_erase, n_erase;
    logic signed [WORD_W-1:0] r_rd_data;
    logic        [AW-1:0]     r_res_found, n_res_found;
    t_status                  r_res_status, n_res_status;
    logic                     r_use_rd, n_use_rd;
    logic                     r_o_valid, n_o_valid;
    logic signed [WORD_W-1:0] r_o_word, n_o_word;
    logic        [POS_W-1:0]  r_o_found, n_o_found;
    t_status                  r_o_status, n_o_status;
    logic        [OCC_W-1:0]  r_o_occ, n_o_occ;

    logic                     rd_en, wr_en;
    logic        [AW-1:0]     rd_addr, wr_addr, last_addr;
    logic signed [WORD_W-1:0] wr_data;
    logic                     accept, in_range, issue, hit, out_free;

    assign i_req.ready = (r_state == ST_IDLE);
    assign accept      = i_req.valid && (r_state == ST_IDLE);
    assign in_range    = PW'(i_req.position) < PW'(r_count);
    assign last_addr   = AW'(r_count - CW'(1));
    assign issue       = r_scan < r_count;
    assign hit         = r_cmp_valid && (r_rd_data == r_key);
    assign out_free    = !r_o_valid || o_rsp.ready;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_scan       = r_scan;
        n_cmp_valid  = r_cmp_valid;
        n_cmp_idx    = r_cmp_idx;
        n_key        = r_key;
        n_tgt        = r_tgt;
        n_erase      = r_erase;
        n_res_found  = r_res_found;
        n_res_status = r_res_status;
        n_use_rd     = r_use_rd;
        n_o_valid    = r_o_valid && !o_rsp.ready;
        n_o_word     = r_o_word;
        n_o_found    = r_o_found;
        n_o_status   = r_o_status;
        n_o_occ      = r_o_occ;
        rd_en        = 1'b0;
        rd_addr      = '0;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = i_req.word;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_res_found  = '0;
                    n_res_status = STAT_OK;
                    n_use_rd     = 1'b0;
                    n_state      = ST_DONE;
                    unique case (t_action'(i_req.action))
                        ACT_PUSH: begin
                            if (r_count >= CAP_C) begin
                                n_res_status = STAT_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = r_count[AW-1:0];
                                n_count = r_count + CW'(1);
                            end
                        end
                        ACT_POP: begin
                            if (r_count == '0) begin
                                n_res_status = STAT_EMPTY;
                            end else begin
                                n_count = r_count - CW'(1);
                            end
                        end
                        ACT_REMOVE: begin
                            if (!in_range) begin
                                n_res_status = STAT_RANGE;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = last_addr;
                                n_tgt   = AW'(i_req.position);
                                n_state = ST_MOVE;
                            end
                        end
                        ACT_ERASE, ACT_FIND: begin
                            n_key       = i_req.word;
                            n_scan      = '0;
                            n_cmp_valid = 1'b0;
                            n_erase     = (t_action'(i_req.action) == ACT_ERASE);
                            n_state     = ST_SCAN;
                        end
                        ACT_READ: begin
                            if (!in_range) begin
                                n_res_status = STAT_RANGE;
                            end else begin
                                rd_en    = 1'b1;
                                rd_addr  = AW'(i_req.position);
                                n_use_rd = 1'b1;
                            end
                        end
                        ACT_WRITE: begin
                            if (!in_range) begin
                                n_res_status = STAT_RANGE;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = AW'(i_req.position);
                            end
                        end
                        ACT_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                priority if (hit) begin
                    n_res_found = r_cmp_idx;
                    if (r_erase) begin
                        rd_en   = 1'b1;
                        rd_addr = last_addr;
                        n_tgt   = r_cmp_idx;
                        n_state = ST_MOVE;
                    end else begin
                        n_state = ST_DONE;
                    end
                end else if (issue) begin
                    rd_en       = 1'b1;
                    rd_addr     = r_scan[AW-1:0];
                    n_scan      = r_scan + CW'(1);
                    n_cmp_valid = 1'b1;
                    n_cmp_idx   = r_scan[AW-1:0];
                end else begin
                    n_res_status = STAT_NOTFOUND;
                    n_state      = ST_DONE;
                end
            end
            ST_MOVE: begin
                // last entry fills the freed slot
                wr_en   = 1'b1;
                wr_addr = r_tgt;
                wr_data = r_rd_data;
                n_count = r_count - CW'(1);
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_word   = r_use_rd ? r_rd_data : '0;
                    n_o_found  = POS_W'(r_res_found);
                    n_o_status = r_res_status;
                    n_o_occ    = OCC_W'(r_count);
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan       <= n_scan;
        r_cmp_valid  <= n_cmp_valid;
        r_cmp_idx    <= n_cmp_idx;
        r_key        <= n_key;
        r_tgt        <= n_tgt;
        r_erase      <= n_erase;
        r_res_found  <= n_res_found;
        r_res_status <= n_res_status;
        r_use_rd     <= n_use_rd;
        r_o_word     <= n_o_word;
        r_o_found    <= n_o_found;
        r_o_status   <= n_o_status;
        r_o_occ      <= n_o_occ;
    end

    assign o_rsp.valid          = r_o_valid;
    assign o_rsp.read_word      = r_o_word;
    assign o_rsp.found_position = r_o_found;
    assign o_rsp.status         = r_o_status;
    assign o_rsp.occupancy      = r_o_occ;

endmodule

`default_nettype wire

// ===== design/ulte_checker.sv =====
// ----------------------------------------------------------------------------
// ulte_checker
// Port-level checks on the result channel of the list engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "unordered_list_table_engine_core_assert.svh"

module ulte_checker #(
    parameter int CAPACITY = 256
) (
    input wire logic                                 i_clk,
    input wire logic                                 i_rst_n,
    input wire logic                                 i_rsp_valid,
    input wire logic                                 i_rsp_ready,
    input wire logic signed [ulte_pkg::WORD_W-1:0]   i_read_word,
    input wire logic        [ulte_pkg::POS_W-1:0]    i_found_position,
    input wire logic        [ulte_pkg::STATUS_W-1:0] i_status,
    input wire logic        [ulte_pkg::OCC_W-1:0]    i_occupancy
);
    import ulte_pkg::*;

    `ULTE_ASSERT_NEXT(a_rsp_hold, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_read_word) && $stable(i_status) && $stable(i_occupancy), "stalled result changed")
    `ULTE_ASSERT_NOW(a_status_code, i_rsp_valid, i_status <= STAT_EMPTY, "status code out of range")
    `ULTE_ASSERT_NOW(a_fail_zero, i_rsp_valid && (i_status != STAT_OK), (i_read_word == 0) && (i_found_position == 0), "failed request carries data")
    `ULTE_ASSERT_NOW(a_occ_cap, i_rsp_valid, int'(i_occupancy) <= CAPACITY, "occupancy beyond capacity")

endmodule

bind unordered_list_table_engine_core ulte_checker #(
    .CAPACITY (CAPACITY)
) u_ulte_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_rsp_valid      (o_rsp.valid),
    .i_rsp_ready      (o_rsp.ready),
    .i_read_word      (o_rsp.read_word),
    .i_found_position (o_rsp.found_position),
    .i_status         (o_rsp.status),
    .i_occupancy      (o_rsp.occupancy)
);

`default_nettype wire
